### rtl/core/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// shared types and constants of the bounded message fifo
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LEN  = 2'd1,
        S_DATA = 2'd2
    } rd_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  wr_byte;
        logic               wr_has_byte;
        logic               wr_last;
        logic [LEN_W-1:0]   rd_max;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [BYTE_W-1:0]  rd_byte;
        logic               rd_byte_valid;
        logic               done_res;
        logic [LEN_W-1:0]   byte_total;
    } res_item_t;

endpackage

### rtl/core/bounded_message_fifo_unit.sv
// ----------------------------------------------------------------------------
// bounded_message_fifo_unit
// ring of fixed-size message slots held in a data memory and a length memory
// ----------------------------------------------------------------------------
// write items: one per cycle while the unit is not busy, commit result in the cycle after the last item
// read request: busy in the length-read state S_LEN, then in S_DATA for the n bytes returned,
//   n set by the length read; the bytes then follow one per cycle
// empty-queue read: the unit stays idle, result on the next cycle
// reset clears pointers and counters; slot memories are not cleared
// results are strobed for one cycle; the receiver cannot stall
module bounded_message_fifo_unit
    import bmf_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int MAX_BYTES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_item_t            item,
    output logic                result_valid,
    output res_item_t           result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data
);

    localparam int SW    = $clog2(SLOTS);
    localparam int OW    = $clog2(SLOTS + 1);
    localparam int DEPTH = SLOTS * MAX_BYTES;
    localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] slot_data_mem [DEPTH];
    logic [LEN_W-1:0]  slot_length_mem [SLOTS];

    rd_state_t          state_reg, state_next;
    logic [SW-1:0]      head_reg, head_next;
    logic [SW-1:0]      tail_reg, tail_next;
    logic [OW-1:0]      occ_reg, occ_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic               in_msg_reg, in_msg_next;
    logic               drop_reg, drop_next;
    logic [LEN_W-1:0]   msg_bytes_reg;
    logic [LEN_W-1:0]   rmax_reg, rmax_next;
    logic [LEN_W-1:0]   n_reg, n_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [DAW-1:0]     base_reg, base_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_next;

    logic [LEN_W-1:0]   len_rd_reg;
    logic [BYTE_W-1:0]  data_rd_reg;

    logic               accept;
    logic               wr_accept;
    logic               rd_accept;
    logic [LEN_W-1:0]   limit;
    logic               first;
    logic [LEN_W-1:0]   fill_cur;
    logic               drop_cur;
    logic               store;
    logic [LEN_W-1:0]   fill_new;
    logic               commit;
    logic [LEN_W-1:0]   n_calc;
    logic               fin;
    logic [DAW-1:0]     tail_base;
    logic [DAW-1:0]     head_base;
    logic [DAW-1:0]     data_waddr;
    logic [DAW-1:0]     data_raddr;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign wr_accept = accept && (item.kind == KIND_WRITE);
    assign rd_accept = accept && (item.kind == KIND_READ);

    assign limit = (msg_bytes_reg < LEN_W'(MAX_BYTES)) ? msg_bytes_reg : LEN_W'(MAX_BYTES);

    assign tail_base  = DAW'(tail_reg) * DAW'(MAX_BYTES);
    assign head_base  = DAW'(head_reg) * DAW'(MAX_BYTES);
    assign data_waddr = tail_base + DAW'(fill_cur);

    // write message bookkeeping
    assign first    = !in_msg_reg;
    assign fill_cur = first ? '0 : fill_reg;
    assign drop_cur = first ? (occ_reg == OW'(SLOTS)) : drop_reg;
    assign store    = !drop_cur && item.wr_has_byte && (fill_cur < limit);
    assign fill_new = fill_cur + LEN_W'(store);
    assign commit   = wr_accept && item.wr_last && !drop_cur;

    // read length and byte index
    always_comb
    begin
        n_calc = (rmax_reg < len_rd_reg) ? rmax_reg : len_rd_reg;
        if (n_calc > LEN_W'(MAX_BYTES))
        begin
            n_calc = LEN_W'(MAX_BYTES);
        end
    end

    assign fin = (idx_reg + LEN_W'(1)) == n_reg;

    always_comb
    begin
        data_raddr = base_reg;
        if (state_reg == S_DATA && !fin)
        begin
            data_raddr = base_reg + DAW'(idx_reg) + DAW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (rd_accept && occ_reg != '0)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                state_next = (n_calc == '0) ? S_IDLE : S_DATA;
            end
            S_DATA:
            begin
                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // datapath and results
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        fill_next      = fill_reg;
        in_msg_next    = in_msg_reg;
        drop_next      = drop_reg;
        rmax_next      = rmax_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        res_valid_next = 1'b0;
        res_next       = '{status: ST_OK, rd_byte: '0, rd_byte_valid: 1'b0,
                           done_res: 1'b1, byte_total: '0};
        case (state_reg)
            S_IDLE:
            begin
                if (wr_accept)
                begin
                    if (item.wr_last)
                    begin
                        in_msg_next    = 1'b0;
                        drop_next      = 1'b0;
                        fill_next      = '0;
                        res_valid_next = 1'b1;
                        if (drop_cur)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.byte_total = fill_new;
                            tail_next = (tail_reg == SW'(SLOTS - 1)) ? '0 : tail_reg + SW'(1);
                            occ_next  = occ_reg + OW'(1);
                        end
                    end
                    else
                    begin
                        in_msg_next = 1'b1;
                        drop_next   = drop_cur;
                        fill_next   = fill_new;
                    end
                end
                else if (rd_accept)
                begin
                    if (occ_reg == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rmax_next = item.rd_max;
                        base_next = head_base;
                        head_next = (head_reg == SW'(SLOTS - 1)) ? '0 : head_reg + SW'(1);
                        occ_next  = occ_reg - OW'(1);
                    end
                end
            end
            S_LEN:
            begin
                n_next   = n_calc;
                idx_next = '0;
                if (n_calc == '0)
                begin
                    res_valid_next = 1'b1;
                end
            end
            S_DATA:
            begin
                res_valid_next         = 1'b1;
                res_next.rd_byte       = data_rd_reg;
                res_next.rd_byte_valid = 1'b1;
                res_next.done_res      = fin;
                res_next.byte_total    = fin ? n_reg : '0;
                idx_next               = idx_reg + LEN_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            fill_reg      <= '0;
            in_msg_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            msg_bytes_reg <= LEN_W'(64);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            fill_reg      <= fill_next;
            in_msg_reg    <= in_msg_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                msg_bytes_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rmax_reg <= rmax_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    // slot data memory
    always_ff @(posedge clk)
    begin
        if (wr_accept && store)
        begin
            slot_data_mem[data_waddr] <= item.wr_byte;
        end
        data_rd_reg <= slot_data_mem[data_raddr];
    end

    // slot length memory
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            slot_length_mem[tail_reg] <= fill_new;
        end
        len_rd_reg <= slot_length_mem[head_reg];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
